/* design/cmsc_pkg.sv */
package cmsc_pkg;

  localparam int          CNT_W       = 32;
  localparam int          COEF_W      = 32;
  localparam int          KEY_W       = 64;
  localparam int          NUM_COEFS   = 4;
  localparam int          COEF_IDX_W  = $clog2(NUM_COEFS);
  localparam int          PADDR_W     = $clog2(NUM_COEFS * 4);
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam int          ROWS_DEF      = 4;
  localparam int          COLUMNS_DEF   = 1024;
  localparam logic [31:0] HASH_MASK_DEF = 32'h7FFF_FFFF;

  // register stages in the column hash, key register to column register
  localparam int          HASH_LAT    = 5;
  localparam int          HCNT_W      = $clog2(HASH_LAT);

  localparam logic [COEF_W-1:0] COEF_RESET [NUM_COEFS] = '{32'd1, 32'd3, 32'd5, 32'd7};

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_EST   = 2'd1,
    REQ_HALVE = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_UPDATE,
    ST_HALVE,
    ST_DONE
  } state_t;

endpackage

/* design/count_min_sketch_conservative.sv */
// Add and estimate: the key passes the 5-stage column hash, then the counter
// banks are read and, for add, written back; the result leaves the done state
// and no new input is taken until the block is back in idle. Halve: one sweep
// over the columns. After reset a clearing pass zeroes the counters while
// in_stall is held; coefficients return to 1, 3, 5, 7.
module count_min_sketch_conservative #(
  parameter int          ROWS      = cmsc_pkg::ROWS_DEF,
  parameter int          COLUMNS   = cmsc_pkg::COLUMNS_DEF,
  parameter logic [31:0] HASH_MASK = cmsc_pkg::HASH_MASK_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_req_type,
  input  logic [cmsc_pkg::KEY_W-1:0]      in_key,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cmsc_pkg::CNT_W-1:0]      out_count_estimate,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cmsc_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import cmsc_pkg::*;

  localparam int COL_W = $clog2(COLUMNS);
  localparam int SWP_W = $clog2(COLUMNS + 1);

  state_t              state_r, state_nxt;
  req_t                type_r;
  logic [KEY_W-1:0]    key_r;
  logic [HCNT_W-1:0]   hcnt_r, hcnt_nxt;
  logic [SWP_W-1:0]    swp_r, swp_nxt;
  logic [SWP_W-1:0]    swp_prev;
  logic [CNT_W-1:0]    res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]    out_data_r;
  logic [COEF_W-1:0]   coef_r [NUM_COEFS];

  logic                in_acc;
  logic                out_free;
  logic                cfg_wr;

  logic [COL_W-1:0]    col     [ROWS];
  logic [CNT_W-1:0]    rd_data [ROWS];
  logic [COL_W-1:0]    rd_addr [ROWS];
  logic [COL_W-1:0]    wr_addr [ROWS];
  logic [CNT_W-1:0]    wr_data [ROWS];
  logic                mem_re;
  logic [ROWS-1:0]     mem_we;
  logic [CNT_W-1:0]    row_min;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign swp_prev = swp_r - SWP_W'(1);

  assign pready             = 1'b1;
  assign prdata             = coef_r[paddr[PADDR_W-1:2]];
  assign out_valid          = out_valid_r;
  assign out_count_estimate = out_data_r;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFS; i++) coef_r[i] <= COEF_RESET[i];
    end else if (cfg_wr) begin
      coef_r[paddr[PADDR_W-1:2]] <= pwdata;
    end
  end

  // per-row column hash and counter bank
  for (genvar r = 0; r < ROWS; r++) begin : g_row
    logic [CNT_W-1:0] mem [COLUMNS];
    logic [CNT_W-1:0] rdata_r;

    cmsc_hash #(
      .COLUMNS   (COLUMNS),
      .HASH_MASK (HASH_MASK)
    ) u_hash (
      .clk  (clk),
      .key  (key_r),
      .coef (coef_r[COEF_IDX_W'(r % NUM_COEFS)]),
      .col  (col[r])
    );

    always_ff @(posedge clk) begin
      if (mem_we[r]) begin
        mem[wr_addr[r]] <= wr_data[r];
      end
      if (mem_re) begin
        rdata_r <= mem[rd_addr[r]];
      end
    end

    assign rd_data[r] = rdata_r;
  end

  always_comb begin
    row_min = COUNT_MAX;
    for (int r = 0; r < ROWS; r++) begin
      if (rd_data[r] < row_min) row_min = rd_data[r];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (swp_r == SWP_W'(COLUMNS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (req_t'(in_req_type))
            REQ_ADD, REQ_EST: state_nxt = ST_HASH;
            REQ_HALVE:        state_nxt = ST_HALVE;
            default:          state_nxt = ST_DONE;
          endcase
        end
      end
      ST_HASH: begin
        if (hcnt_r == HCNT_W'(HASH_LAT - 1)) state_nxt = ST_READ;
      end
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_DONE;
      ST_HALVE: begin
        if (swp_r == SWP_W'(COLUMNS)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    hcnt_nxt      = hcnt_r;
    swp_nxt       = swp_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_re        = 1'b0;
    mem_we        = '0;
    for (int r = 0; r < ROWS; r++) begin
      rd_addr[r] = col[r];
      wr_addr[r] = col[r];
      wr_data[r] = row_min + CNT_W'(1);
    end
    case (state_r)
      ST_CLEAR: begin
        mem_we  = '1;
        swp_nxt = (swp_r == SWP_W'(COLUMNS - 1)) ? '0 : swp_r + SWP_W'(1);
        for (int r = 0; r < ROWS; r++) begin
          wr_addr[r] = swp_r[COL_W-1:0];
          wr_data[r] = '0;
        end
      end
      ST_IDLE: begin
        hcnt_nxt = '0;
        swp_nxt  = '0;
        res_nxt  = '0;
      end
      ST_HASH: begin
        hcnt_nxt = hcnt_r + HCNT_W'(1);
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_UPDATE: begin
        if (type_r == REQ_EST) begin
          res_nxt = row_min;
        end else if (row_min != COUNT_MAX) begin
          // conservative update: only rows sitting at the minimum move
          for (int r = 0; r < ROWS; r++) mem_we[r] = (rd_data[r] == row_min);
        end
      end
      ST_HALVE: begin
        // read column n while writing back column n-1
        mem_re  = (swp_r != SWP_W'(COLUMNS));
        swp_nxt = (swp_r == SWP_W'(COLUMNS)) ? '0 : swp_r + SWP_W'(1);
        for (int r = 0; r < ROWS; r++) begin
          rd_addr[r] = swp_r[COL_W-1:0];
          wr_addr[r] = swp_prev[COL_W-1:0];
          wr_data[r] = rd_data[r] >> 1;
          mem_we[r]  = (swp_r != '0);
        end
      end
      ST_DONE: begin
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      hcnt_r      <= '0;
      swp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hcnt_r      <= hcnt_nxt;
      swp_r       <= swp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_acc) begin
      key_r  <= in_key;
      type_r <= req_t'(in_req_type);
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= res_r;
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_DONE))
    else $error("result transaction not issued from completion state");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we != '0) |->
      (state_r == ST_CLEAR || state_r == ST_UPDATE || state_r == ST_HALVE))
    else $error("counter write outside clear, update or halve");

  a_add_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && type_r == REQ_ADD && row_min != COUNT_MAX) |->
      (mem_we != '0))
    else $error("add left every row at the minimum unchanged");

  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (in_stall && !out_valid_r))
    else $error("transaction activity during clearing pass");

endmodule

/* design/cmsc_hash.sv */
module cmsc_hash #(
  parameter int          COLUMNS   = cmsc_pkg::COLUMNS_DEF,
  parameter logic [31:0] HASH_MASK = cmsc_pkg::HASH_MASK_DEF
) (
  input  logic                           clk,
  input  logic [cmsc_pkg::KEY_W-1:0]     key,
  input  logic [cmsc_pkg::COEF_W-1:0]    coef,
  output logic [$clog2(COLUMNS)-1:0]     col
);
  import cmsc_pkg::*;

  localparam int          COL_W   = $clog2(COLUMNS);
  localparam int          REM_W   = COL_W + 1;
  localparam logic [63:0] RECIP64 = (64'd1 << 32) / COLUMNS;
  localparam logic [31:0] RECIP   = RECIP64[31:0];
  localparam logic [REM_W-1:0] COLS_REM = REM_W'(COLUMNS);

  logic [63:0]      lo_prod_r;
  logic [31:0]      hi_prod_r;
  logic [31:0]      fold_r;
  logic [31:0]      quot_r;
  logic [31:0]      fold_d_r;
  logic [REM_W-1:0] rem_r;
  logic [COL_W-1:0] col_r;

  logic [63:0] hi_full;
  logic [63:0] recip_prod;
  logic [63:0] back_prod;
  logic [31:0] rem_full;

  assign hi_full    = coef * key[63:32];
  assign recip_prod = fold_r * RECIP;
  assign back_prod  = quot_r * 32'(COLUMNS);
  assign rem_full   = fold_d_r - back_prod[31:0];

  // upper half of the 64-bit product only feeds bits 63:32, so the fold
  // (h + h>>32) reduces to a 32-bit three-term sum ahead of the mask.
  // quotient estimate from the reciprocal is exact or one low, so the
  // remainder stays below twice the column count.
  always_ff @(posedge clk) begin
    lo_prod_r <= coef * key[31:0];
    hi_prod_r <= hi_full[31:0];
    fold_r    <= (lo_prod_r[31:0] + lo_prod_r[63:32] + hi_prod_r) & HASH_MASK;
    quot_r    <= recip_prod[63:32];
    fold_d_r  <= fold_r;
    rem_r     <= rem_full[REM_W-1:0];
    col_r     <= (rem_r >= COLS_REM) ? COL_W'(rem_r - COLS_REM) : rem_r[COL_W-1:0];
  end

  assign col = col_r;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import cmsc_pkg::*;

  localparam int          NROWS    = ROWS_DEF;
  localparam int          NCOLS    = COLUMNS_DEF;
  localparam logic [31:0] HMASK    = HASH_MASK_DEF;
  localparam int          AW       = PADDR_W;
  localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
  localparam int          POOL     = 24;
  localparam int          NPHASES  = 7;
  localparam int          PHASE_ITEMS = 240;

  typedef struct {
    logic [1:0]       req;
    logic [KEY_W-1:0] key;
    bit               typed;
    logic [CNT_W-1:0] want;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_req_type;
  logic [KEY_W-1:0] in_key;
  logic             out_valid;
  logic             out_stall;
  logic [CNT_W-1:0] out_count_estimate;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AW-1:0]    paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  logic [CNT_W-1:0]  sketch_cnt [NROWS][NCOLS];
  logic [COEF_W-1:0] row_coef [NUM_COEFS];
  logic [CNT_W-1:0]  pending_estimates [$];
  logic [KEY_W-1:0]  key_pool [POOL];
  logic [CNT_W-1:0]  got_estimate;
  int                errors;
  bit                idle_en;
  bit                hold_req;

  stim_row_t directed_tab [23] = '{
    '{REQ_EST,     64'd0,                  1'b1, 32'd0},
    '{REQ_EST,     '1,                     1'b1, 32'd0},
    '{REQ_EST,     64'h8000_0000_0000_0000, 1'b1, 32'd0},
    '{REQ_ADD,     64'd0,                  1'b1, 32'd0},
    '{REQ_ADD,     64'd0,                  1'b1, 32'd0},
    '{REQ_EST,     64'd0,                  1'b1, 32'd2},
    '{REQ_ADD,     '1,                     1'b1, 32'd0},
    '{REQ_ADD,     64'h8000_0000_0000_0000, 1'b1, 32'd0},
    '{REQ_EST,     '1,                     1'b0, 32'd0},
    '{REQ_EST,     64'd0,                  1'b0, 32'd0},
    '{REQ_UNKNOWN, 64'd0,                  1'b1, 32'd0},
    '{REQ_UNKNOWN, '1,                     1'b1, 32'd0},
    '{REQ_EST,     64'd0,                  1'b0, 32'd0},
    '{REQ_HALVE,   '1,                     1'b1, 32'd0},
    '{REQ_EST,     64'd0,                  1'b0, 32'd0},
    '{REQ_ADD,     64'd1,                  1'b1, 32'd0},
    '{REQ_ADD,     64'd2,                  1'b1, 32'd0},
    '{REQ_ADD,     64'h0000_0001_0000_0000, 1'b1, 32'd0},
    '{REQ_EST,     64'd1,                  1'b0, 32'd0},
    '{REQ_EST,     64'h0000_0001_0000_0000, 1'b0, 32'd0},
    '{REQ_HALVE,   64'd0,                  1'b1, 32'd0},
    '{REQ_EST,     64'd0,                  1'b0, 32'd0},
    '{REQ_EST,     '1,                     1'b0, 32'd0}
  };

  count_min_sketch_conservative u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_key             (in_key),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_count_estimate (out_count_estimate),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40) begin
      $display("tb: mismatch (%s) got %0h want %0h at %0t", what, got, want, $realtime);
    end
  endtask

  function automatic int sketch_column(logic [KEY_W-1:0] key, int row);
    logic [63:0] h;
    h = {32'd0, row_coef[row % NUM_COEFS]} * key;
    h = h + (h >> 32);
    h = h & {32'd0, HMASK};
    return int'(h % 64'(NCOLS));
  endfunction

  // Applies one transaction to the shadow sketch, returns the expected estimate.
  function automatic logic [CNT_W-1:0] sketch_step(logic [1:0] req, logic [KEY_W-1:0] key);
    int               cols [NROWS];
    logic [CNT_W-1:0] lo;
    lo = COUNT_MAX;
    if (req == REQ_ADD || req == REQ_EST) begin
      for (int r = 0; r < NROWS; r++) begin
        cols[r] = sketch_column(key, r);
        if (sketch_cnt[r][cols[r]] < lo) lo = sketch_cnt[r][cols[r]];
      end
      if (req == REQ_EST) return lo;
      // conservative update: only counters sitting at the minimum move
      if (lo != COUNT_MAX) begin
        for (int r = 0; r < NROWS; r++) begin
          if (sketch_cnt[r][cols[r]] == lo) sketch_cnt[r][cols[r]] = lo + 1;
        end
      end
    end else if (req == REQ_HALVE) begin
      for (int r = 0; r < NROWS; r++) begin
        for (int c = 0; c < NCOLS; c++) sketch_cnt[r][c] = sketch_cnt[r][c] >> 1;
      end
    end
    return '0;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_item(logic [1:0] req, logic [KEY_W-1:0] key, bit typed,
                           logic [CNT_W-1:0] typed_want);
    logic [CNT_W-1:0] want;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_key      <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = sketch_step(req, key);
    if (typed) want = typed_want;
    pending_estimates.insert(pending_estimates.size(), want);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk);
    // the last result is issued from the done state, so no sweep is still running here
    repeat (12) @(negedge clk);
  endtask

  task automatic coef_write(int idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(idx * 4);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    row_coef[idx] = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== val) report_mismatch("coef readback", prdata, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random(int n, int drain_at);
    int               pick;
    logic [1:0]       req;
    logic [KEY_W-1:0] key;
    for (int i = 0; i < n; i++) begin
      if (i == drain_at) wait_drain();
      pick = $urandom_range(0, 99);
      if (pick < 2) req = REQ_HALVE;
      else if (pick < 6) req = REQ_UNKNOWN;
      else if (pick < 58) req = REQ_ADD;
      else req = REQ_EST;
      // mostly repeat keys so counts build up and rows collide
      if ($urandom_range(0, 9) < 7) key = key_pool[$urandom_range(0, POOL - 1)];
      else key = {$urandom, $urandom};
      send_item(req, key, 1'b0, '0);
    end
  endtask

  // receiver side: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch("result with no transaction pending", out_count_estimate, '0);
      end else begin
        got_estimate = pending_estimates.pop_front();
        if (out_count_estimate !== got_estimate) begin
          report_mismatch("count_estimate", out_count_estimate, got_estimate);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [31:0] c;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_ADD;
    in_key      = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    errors      = 0;
    idle_en     = 1'b1;
    hold_req    = 1'b0;
    for (int i = 0; i < NUM_COEFS; i++) row_coef[i] = COEF_RESET[i];
    for (int r = 0; r < NROWS; r++) begin
      for (int k = 0; k < NCOLS; k++) sketch_cnt[r][k] = '0;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (in_stall) @(negedge clk);

    for (int i = 0; i < $size(directed_tab); i++) begin
      send_item(directed_tab[i].req, directed_tab[i].key, directed_tab[i].typed,
                directed_tab[i].want);
    end

    for (int p = 1; p <= NPHASES; p++) begin
      wait_drain();
      case (p)
        1: begin
          coef_write(0, 32'h0000_0000);
          coef_write(1, 32'hFFFF_FFFF);
          coef_write(2, 32'h0000_0001);
          coef_write(3, 32'hFFFF_FFFE);
        end
        2: begin
          coef_write(0, 32'hFFFF_FFFF);
          coef_write(1, 32'h0000_0000);
          coef_write(2, 32'hFFFF_FFFE);
          coef_write(3, 32'h0000_0001);
        end
        4: begin
          // every row hashes alike, so each key addresses the same column in all rows
          c = $urandom;
          for (int i = 0; i < NUM_COEFS; i++) coef_write(i, c);
        end
        default: begin
          for (int i = 0; i < NUM_COEFS; i++) coef_write(i, $urandom);
        end
      endcase
      for (int i = 0; i < POOL; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = 64'h8000_0000_0000_0000;
      key_pool[3] = {32'd0, $urandom};
      if (p == 2) hold_req = 1'b1;
      if (p == NPHASES) idle_en = 1'b0;
      run_random(PHASE_ITEMS, (p == 3) ? PHASE_ITEMS / 2 : -1);
    end

    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (pending_estimates.size() != 0) begin
      report_mismatch("transactions left without result", pending_estimates.size(), '0);
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
design/cmsc_pkg.sv
design/cmsc_hash.sv
design/count_min_sketch_conservative.sv
verif/tb.sv
